/* hw/rtl/audio_buffer_fetch_controller_top_assert.svh */
// Assertion macros shared by the checker of the audio fetch controller.
`ifndef AUDIO_BUFFER_FETCH_CONTROLLER_TOP_ASSERT_SVH
`define AUDIO_BUFFER_FETCH_CONTROLLER_TOP_ASSERT_SVH

// Clocked assertion, disabled while reset is asserted.
`define ABFC_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Clocked assertion that is also checked during reset.
`define ABFC_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

/* hw/rtl/abfc_pkg.sv */
// ----------------------------------------------------------------------------
// abfc_pkg
// Shared types and constants of the audio buffer fetch controller.
// ----------------------------------------------------------------------------
package abfc_pkg;

  localparam int unsigned LenW = 7;

  localparam logic [31:0] SupportedFormats = 32'h0000_0069;

  localparam logic [4:0] Bits8  = 5'd8;
  localparam logic [4:0] Bits16 = 5'd16;
  localparam logic [4:0] Bits24 = 5'd24;

  // Request kinds carried on req_type
  typedef enum logic [1:0] {
    REQ_WRITE = 2'd0,
    REQ_READ  = 2'd1,
    REQ_FETCH = 2'd2,
    REQ_TICK  = 2'd3
  } req_e;

  // Word register map
  typedef enum logic [2:0] {
    REG_CTRL      = 3'd0,
    REG_SCTRL     = 3'd1,
    REG_PRESC     = 3'd2,
    REG_FORMAT    = 3'd3,
    REG_SUPPORT   = 3'd4,
    REG_NEXT_ADDR = 3'd5,
    REG_NEXT_SIZE = 3'd6,
    REG_RD_OFFSET = 3'd7
  } reg_e;

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_DECIDE,
    ST_COUNT,
    ST_RESP,
    ST_EMIT
  } state_e;

  // Controller to datapath commands
  typedef struct packed {
    logic capture;
    logic exec;
    logic decide;
    logic count;
    logic load_single;
    logic load_addr;
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    req_e req;
    logic rem_zero;
    logic pend_zero;
    logic count_zero;
    logic cnt_one;
    logic out_free;
  } status_t;

endpackage

/* hw/rtl/abfc_dp.sv */
// ----------------------------------------------------------------------------
// abfc_dp
// Register file, buffer bookkeeping, interrupt timer, address generator and
// output register of the audio buffer fetch controller.
// ----------------------------------------------------------------------------
module abfc_dp import abfc_pkg::*; #(
  parameter int unsigned MaxBurst     = 64,
  parameter int unsigned IrqHoldTicks = 10
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  cmd_t             cmd_i,
  output status_t          status_o,
  input  logic [1:0]       req_type_i,
  input  logic [2:0]       reg_offset_i,
  input  logic [31:0]      write_data_i,
  input  logic [LenW-1:0]  fetch_length_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [31:0]      read_data_o,
  output logic [31:0]      mem_addr_o,
  output logic             addr_valid_o,
  output logic             last_o,
  output logic             irq_line_o,
  output logic             playback_active_o,
  output logic [4:0]       sample_bits_o,
  output logic             samples_signed_o,
  output logic             samples_float_o,
  output logic             stereo_mode_o
);

  typedef struct packed {
    logic        general_play;
    logic        sample_enable;
    logic        stereo_flag;
    logic        switch_irq_enable;
    logic        switch_irq_flag;
    logic [31:0] prescaler_word;
    logic [31:0] format_word;
    logic [4:0]  bits_code;
    logic        signed_flag;
    logic        float_flag;
    logic [31:0] pending_addr;
    logic [31:0] pending_size;
    logic [31:0] read_offset;
    logic [31:0] active_addr;
    logic [31:0] active_size;
    logic        irq_pending;
    logic [3:0]  irq_ticks;
    logic        irq_level;
    logic        backend_running;
  } arch_t;

  localparam logic [LenW-1:0] BurstMax = LenW'(MaxBurst);
  localparam logic [4:0]      HoldMax  = 5'(IrqHoldTicks);

  arch_t           arch_d, arch_q;
  req_e            req_q;
  reg_e            off_q;
  logic [31:0]     wdata_q;
  logic [LenW-1:0] flen_q;
  logic [31:0]     rem_d, rem_q;
  logic [LenW-1:0] len_d, len_q;
  logic [LenW-1:0] cnt_d, cnt_q;
  logic [LenW-1:0] count_val;
  logic [31:0]     rd_val;
  logic            out_valid_q;
  logic            out_free;

  // Request capture
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      req_q   <= req_e'(req_type_i);
      off_q   <= reg_e'(reg_offset_i);
      wdata_q <= write_data_i;
      flen_q  <= fetch_length_i;
    end
  end

  // Burst count: shorter of request length and remaining bytes
  assign count_val = (32'(len_q) < rem_q) ? len_q : rem_q[LenW-1:0];

  // Register readback
  always_comb begin
    case (off_q)
      REG_CTRL:      rd_val = {31'd0, arch_q.general_play};
      REG_SCTRL:     rd_val = {28'd0, arch_q.switch_irq_flag, arch_q.switch_irq_enable,
                               arch_q.stereo_flag, arch_q.sample_enable};
      REG_PRESC:     rd_val = arch_q.prescaler_word;
      REG_FORMAT:    rd_val = arch_q.format_word;
      REG_SUPPORT:   rd_val = SupportedFormats;
      REG_NEXT_ADDR: rd_val = arch_q.pending_addr;
      REG_NEXT_SIZE: rd_val = arch_q.pending_size;
      default:       rd_val = arch_q.read_offset;
    endcase
  end

  // State update
  always_comb begin
    arch_d = arch_q;
    rem_d  = rem_q;
    len_d  = len_q;
    cnt_d  = cnt_q;

    if (cmd_i.exec) begin
      case (req_q)
        REQ_WRITE: begin
          case (off_q)
            REG_CTRL: arch_d.general_play = wdata_q[0];
            REG_SCTRL: begin
              arch_d.sample_enable     = wdata_q[0];
              arch_d.stereo_flag       = wdata_q[1];
              arch_d.switch_irq_enable = wdata_q[2];
              arch_d.switch_irq_flag   = wdata_q[3];
              if (arch_q.general_play && wdata_q[0]) begin
                arch_d.active_addr     = arch_q.pending_addr;
                arch_d.active_size     = arch_q.pending_size;
                arch_d.backend_running = 1'b1;
                if (wdata_q[2]) begin
                  arch_d.switch_irq_flag = 1'b1;
                  arch_d.irq_pending     = 1'b1;
                end
              end else begin
                arch_d.backend_running = 1'b0;
              end
            end
            REG_PRESC: arch_d.prescaler_word = wdata_q;
            REG_FORMAT: begin
              // lowest set format bit wins; float leaves width and word alone
              arch_d.signed_flag = 1'b0;
              arch_d.float_flag  = 1'b0;
              arch_d.format_word = wdata_q;
              if (wdata_q[0]) begin
                arch_d.bits_code = Bits8;
              end else if (wdata_q[1]) begin
                arch_d.bits_code   = Bits8;
                arch_d.signed_flag = 1'b1;
              end else if (wdata_q[2]) begin
                arch_d.bits_code = Bits16;
              end else if (wdata_q[3]) begin
                arch_d.bits_code   = Bits16;
                arch_d.signed_flag = 1'b1;
              end else if (wdata_q[4]) begin
                arch_d.bits_code = Bits24;
              end else if (wdata_q[5]) begin
                arch_d.bits_code   = Bits24;
                arch_d.signed_flag = 1'b1;
              end else if (wdata_q[6]) begin
                arch_d.float_flag  = 1'b1;
                arch_d.format_word = arch_q.format_word;
              end
            end
            REG_NEXT_ADDR: arch_d.pending_addr = wdata_q;
            REG_NEXT_SIZE: arch_d.pending_size = wdata_q;
            REG_RD_OFFSET: arch_d.read_offset  = wdata_q;
            default: ;
          endcase
        end
        REQ_TICK: begin
          // interrupt hold timer
          if (arch_q.irq_pending) begin
            if (arch_q.irq_ticks == 4'd0) begin
              arch_d.irq_level = 1'b1;
              arch_d.irq_ticks = 4'd1;
            end else if ({1'b0, arch_q.irq_ticks} + 5'd1 > HoldMax) begin
              arch_d.irq_level   = 1'b0;
              arch_d.irq_pending = 1'b0;
              arch_d.irq_ticks   = 4'd0;
            end else begin
              arch_d.irq_ticks = arch_q.irq_ticks + 4'd1;
            end
          end
        end
        REQ_FETCH: begin
          // overrun of the read offset counts as nothing left
          rem_d = (arch_q.read_offset < arch_q.active_size) ?
                  arch_q.active_size - arch_q.read_offset : 32'd0;
          len_d = (flen_q > BurstMax) ? BurstMax : flen_q;
        end
        default: ;
      endcase
    end

    // Buffer used up: switch to the next one or stop
    if (cmd_i.decide && (rem_q == 32'd0)) begin
      if (arch_q.pending_size == 32'd0) begin
        arch_d.backend_running = 1'b0;
        arch_d.sample_enable   = 1'b0;
      end else begin
        arch_d.active_addr = arch_q.pending_addr;
        arch_d.active_size = arch_q.pending_size;
        arch_d.read_offset = 32'd0;
        rem_d              = arch_q.pending_size;
        if (arch_q.switch_irq_enable) begin
          arch_d.switch_irq_flag = 1'b1;
          arch_d.irq_pending     = 1'b1;
        end
      end
    end

    if (cmd_i.count) begin
      cnt_d = count_val;
    end

    // One address per beat
    if (cmd_i.load_addr) begin
      arch_d.read_offset = arch_q.read_offset + 32'd1;
      cnt_d              = cnt_q - LenW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      arch_q <= '0;
      rem_q  <= '0;
      len_q  <= '0;
      cnt_q  <= '0;
    end else begin
      arch_q <= arch_d;
      rem_q  <= rem_d;
      len_q  <= len_d;
      cnt_q  <= cnt_d;
    end
  end

  // Output register
  assign out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_single || cmd_i.load_addr) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_single || cmd_i.load_addr) begin
      read_data_o       <= (cmd_i.load_single && (req_q == REQ_READ)) ? rd_val : 32'd0;
      mem_addr_o        <= cmd_i.load_addr ? arch_q.active_addr + arch_q.read_offset
                                           : 32'd0;
      addr_valid_o      <= cmd_i.load_addr;
      last_o            <= cmd_i.load_single || (cnt_q == LenW'(1));
      irq_line_o        <= arch_q.irq_level;
      playback_active_o <= arch_q.backend_running;
      sample_bits_o     <= arch_q.bits_code;
      samples_signed_o  <= arch_q.signed_flag;
      samples_float_o   <= arch_q.float_flag;
      stereo_mode_o     <= arch_q.stereo_flag;
    end
  end

  assign out_valid_o = out_valid_q;

  // Status to the controller
  assign status_o.req        = req_q;
  assign status_o.rem_zero   = (rem_q == 32'd0);
  assign status_o.pend_zero  = (arch_q.pending_size == 32'd0);
  assign status_o.count_zero = (count_val == '0);
  assign status_o.cnt_one    = (cnt_q == LenW'(1));
  assign status_o.out_free   = out_free;

endmodule

/* hw/rtl/abfc_ctrl.sv */
// ----------------------------------------------------------------------------
// abfc_ctrl
// Sequencer of the audio buffer fetch controller: steps one request through
// execute and, for a fetch, buffer decision and burst count, then result beats.
// ----------------------------------------------------------------------------
module abfc_ctrl import abfc_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  input  status_t status_i,
  output cmd_t    cmd_o
);

  state_e state_d, state_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd_o.exec = 1'b1;
        state_d    = (status_i.req == REQ_FETCH) ? ST_DECIDE : ST_RESP;
      end
      ST_DECIDE: begin
        cmd_o.decide = 1'b1;
        state_d = (status_i.rem_zero && status_i.pend_zero) ? ST_RESP : ST_COUNT;
      end
      ST_COUNT: begin
        cmd_o.count = 1'b1;
        state_d     = status_i.count_zero ? ST_RESP : ST_EMIT;
      end
      ST_RESP: begin
        if (status_i.out_free) begin
          cmd_o.load_single = 1'b1;
          state_d           = ST_IDLE;
        end
      end
      ST_EMIT: begin
        if (status_i.out_free) begin
          cmd_o.load_addr = 1'b1;
          if (status_i.cnt_one) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

/* hw/rtl/audio_buffer_fetch_controller_top.sv */
// ----------------------------------------------------------------------------
// audio_buffer_fetch_controller_top
// Double-buffered audio sample fetch controller with bus register access.
// ----------------------------------------------------------------------------
// One request is worked on at a time. A register write, register read or
// tick steps through capture, execute and respond to its result beat. A
// fetch steps through setup (capture, remaining-byte compute, buffer switch
// or stop decision, burst count) and then emits one address beat per cycle
// while the output register is free; a stalled consumer holds the beats. A
// fetch that emits nothing ends with a single result beat, and one that
// stops playback skips the burst count. A new request is taken as soon as
// the last result beat sits in the output register.
module audio_buffer_fetch_controller_top import abfc_pkg::*; #(
  parameter int unsigned MAX_BURST      = 64,
  parameter int unsigned IRQ_HOLD_TICKS = 10
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  logic [1:0]      req_type_i,
  input  logic [2:0]      reg_offset_i,
  input  logic [31:0]     write_data_i,
  input  logic [LenW-1:0] fetch_length_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic [31:0]     read_data_o,
  output logic [31:0]     mem_addr_o,
  output logic            addr_valid_o,
  output logic            last_o,
  output logic            irq_line_o,
  output logic            playback_active_o,
  output logic [4:0]      sample_bits_o,
  output logic            samples_signed_o,
  output logic            samples_float_o,
  output logic            stereo_mode_o
);

  cmd_t    cmd;
  status_t status;

  abfc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  abfc_dp #(
    .MaxBurst     (MAX_BURST),
    .IrqHoldTicks (IRQ_HOLD_TICKS)
  ) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .status_o          (status),
    .req_type_i        (req_type_i),
    .reg_offset_i      (reg_offset_i),
    .write_data_i      (write_data_i),
    .fetch_length_i    (fetch_length_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .read_data_o       (read_data_o),
    .mem_addr_o        (mem_addr_o),
    .addr_valid_o      (addr_valid_o),
    .last_o            (last_o),
    .irq_line_o        (irq_line_o),
    .playback_active_o (playback_active_o),
    .sample_bits_o     (sample_bits_o),
    .samples_signed_o  (samples_signed_o),
    .samples_float_o   (samples_float_o),
    .stereo_mode_o     (stereo_mode_o)
  );

endmodule

/* hw/rtl/abfc_chk.sv */
// ----------------------------------------------------------------------------
// abfc_chk
// Port-level checker of the audio buffer fetch controller, bound to the top.
// ----------------------------------------------------------------------------
`include "audio_buffer_fetch_controller_top_assert.svh"

module abfc_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [31:0] mem_addr_o,
  input logic        addr_valid_o,
  input logic        last_o
);

  logic        step_go;
  logic        stalled;
  logic [31:0] addr_plus1;

  // accepted burst beat with more to follow, and a beat held by the consumer
  assign step_go    = out_valid_o && out_ready_i && addr_valid_o && !last_o;
  assign stalled    = out_valid_o && !out_ready_i;
  assign addr_plus1 = mem_addr_o + 32'd1;

  // no result beat is shown in the cycle after reset holds
  `ABFC_ASSERT_ALWAYS(a_no_beat_in_reset, !rst_ni |=> !out_valid_o, "beat valid in reset")

  // a beat without an address always closes its request
  `ABFC_ASSERT(a_plain_is_last, out_valid_o && !addr_valid_o |-> last_o, "plain beat not last")

  // burst addresses follow back to back, one byte apart
  `ABFC_ASSERT(a_burst_step, step_go |=> addr_valid_o && mem_addr_o == $past(addr_plus1), "gap")

  // a stalled beat holds its address
  `ABFC_ASSERT(a_stall_hold, stalled |=> out_valid_o && $stable(mem_addr_o), "stall changed")

endmodule

bind audio_buffer_fetch_controller_top abfc_chk u_abfc_chk (.*);
